// File: design/xcfd_pkg.sv
package xcfd_pkg;

    // Frame geometry.
    localparam int unsigned MAX_FRAME = 64;
    localparam int unsigned STORE_AW  = 6;
    localparam int unsigned STORE_DEPTH = 1 << STORE_AW;

    localparam logic [7:0] MIN_FRAME_LEN = 8'd5;
    localparam logic [7:0] MAX_FRAME_LEN = 8'(MAX_FRAME);
    localparam logic [7:0] LEN_ADJ       = 8'd3;
    localparam logic [6:0] OVERHEAD      = 7'd5;
    localparam logic [6:0] CSUM_OFFSET   = 7'd2;
    localparam logic [6:0] PAYLOAD_START = 7'd3;
    localparam logic [6:0] CMD_POS       = 7'd2;

    // Result status codes.
    localparam logic [1:0] STAT_GOOD     = 2'd0;
    localparam logic [1:0] STAT_BAD_TAIL = 2'd1;
    localparam logic [1:0] STAT_BAD_CSUM = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_HEAD_IDX = 1'b0;
    localparam logic CFG_TAIL_IDX = 1'b1;

    typedef enum logic [2:0] {
        ST_HUNT,
        ST_LEN,
        ST_BODY,
        ST_READ,
        ST_SHOW
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start_frame;
        logic load_len;
        logic take_body;
        logic show;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_head;
        logic len_ok;
        logic frame_done;
        logic out_free;
        logic show_last;
    } t_dp_status;

endpackage

// File: design/xcfd_ctrl.sv
module xcfd_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_rx_valid,
    output logic                  o_rx_stall,
    input  xcfd_pkg::t_dp_status  i_st,
    output xcfd_pkg::t_dp_cmd     o_cmd
);
    import xcfd_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   rx_acc;

    assign rx_acc = i_rx_valid && !o_rx_stall;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_HUNT;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state: intake one byte per transaction, then walk the results.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_HUNT: begin
                if (rx_acc && i_st.is_head) n_state = ST_LEN;
            end
            ST_LEN: begin
                if (rx_acc) n_state = i_st.len_ok ? ST_BODY : ST_HUNT;
            end
            ST_BODY: begin
                if (rx_acc && i_st.frame_done) n_state = ST_READ;
            end
            ST_READ: begin
                n_state = ST_SHOW;
            end
            ST_SHOW: begin
                if (i_st.out_free) n_state = i_st.show_last ? ST_HUNT : ST_READ;
            end
            default: begin
                n_state = ST_HUNT;
            end
        endcase
    end

    // Outputs: intake is open only while hunting for a head or parsing a frame.
    always_comb begin
        o_rx_stall        = 1'b1;
        o_cmd.start_frame = 1'b0;
        o_cmd.load_len    = 1'b0;
        o_cmd.take_body   = 1'b0;
        o_cmd.show        = 1'b0;
        unique case (r_state)
            ST_HUNT: begin
                o_rx_stall        = 1'b0;
                o_cmd.start_frame = i_rx_valid && i_st.is_head;
            end
            ST_LEN: begin
                o_rx_stall     = 1'b0;
                o_cmd.load_len = i_rx_valid;
            end
            ST_BODY: begin
                o_rx_stall      = 1'b0;
                o_cmd.take_body = i_rx_valid;
            end
            ST_READ: begin
                o_rx_stall = 1'b1;
            end
            ST_SHOW: begin
                o_cmd.show = i_st.out_free;
            end
            default: begin
                o_rx_stall = 1'b1;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_read_then_show: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_READ |=> r_state == ST_SHOW)
        else $error("memory read not followed by result load");

    a_done_to_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.take_body && i_st.frame_done) |=> r_state == ST_READ)
        else $error("completed frame did not start result output");

    a_bad_len_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.load_len && !i_st.len_ok) |=> r_state == ST_HUNT)
        else $error("bad length byte did not return to hunt");
`endif

endmodule

// File: design/xcfd_dp.sv
module xcfd_dp (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [7:0]            i_rx_byte,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_index,
    input  logic [7:0]            i_cfg_data,
    input  logic                  i_res_stall,
    output logic                  o_res_valid,
    output logic [1:0]            o_status,
    output logic [7:0]            o_command,
    output logic [5:0]            o_body_len,
    output logic [5:0]            o_byte_index,
    output logic [7:0]            o_payload_byte,
    output logic                  o_last,
    input  xcfd_pkg::t_dp_cmd     i_cmd,
    output xcfd_pkg::t_dp_status  o_st
);
    import xcfd_pkg::*;

    logic [7:0] r_head_cfg;
    logic [7:0] r_tail_cfg;
    logic [6:0] r_byte_count;
    logic [6:0] r_exp_len;
    logic [7:0] r_xor;
    logic [7:0] r_cmd_byte;
    logic [7:0] r_csum_byte;
    logic       r_tail_ok;
    logic       r_csum_ok;
    logic [5:0] r_plen;
    logic [5:0] r_idx;
    logic [7:0] r_rdata;
    logic [7:0] r_store [STORE_DEPTH];

    logic       r_out_valid;
    logic [1:0] r_out_status;
    logic [5:0] r_out_index;
    logic [7:0] r_out_byte;
    logic       r_out_last;

    logic [7:0] flen8;
    logic [6:0] pos_next;
    logic       good_payload;
    logic       idx_last;
    logic [6:0] rd_addr;

    // Length byte check and body position arithmetic.
    assign flen8        = i_rx_byte + LEN_ADJ;
    assign pos_next     = r_byte_count + 7'd1;
    assign good_payload = r_tail_ok && r_csum_ok && (r_plen != 6'd0);
    assign idx_last     = (r_idx + 6'd1) == r_plen;
    assign rd_addr      = PAYLOAD_START + {1'b0, r_idx};

    assign o_st.is_head    = (i_rx_byte == r_head_cfg);
    assign o_st.len_ok     = (flen8 >= MIN_FRAME_LEN) && (flen8 <= MAX_FRAME_LEN);
    assign o_st.frame_done = (pos_next >= r_exp_len);
    assign o_st.out_free   = !r_out_valid || !i_res_stall;
    assign o_st.show_last  = !good_payload || idx_last;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_cfg <= 8'd170;
            r_tail_cfg <= 8'd187;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_HEAD_IDX: r_head_cfg <= i_cfg_data;
                CFG_TAIL_IDX: r_tail_cfg <= i_cfg_data;
                default:      r_head_cfg <= r_head_cfg;
            endcase
        end
    end

    // Frame parsing state: count, length, checksum and captured bytes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count <= '0;
            r_exp_len    <= '0;
            r_xor        <= '0;
        end else if (i_cmd.start_frame) begin
            r_byte_count <= 7'd1;
            r_exp_len    <= '0;
            r_xor        <= '0;
        end else if (i_cmd.load_len) begin
            r_byte_count <= 7'd2;
            if (o_st.len_ok) begin
                r_exp_len <= flen8[6:0];
                r_xor     <= i_rx_byte;
            end else begin
                r_byte_count <= '0;
                r_exp_len    <= '0;
            end
        end else if (i_cmd.take_body) begin
            r_byte_count <= pos_next;
            if ((r_byte_count + PAYLOAD_START) <= r_exp_len) begin
                r_xor <= r_xor ^ i_rx_byte;
            end
        end
    end

    // Captured bytes and the verdict at the closing byte.
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_body) begin
            if (r_byte_count == CMD_POS) r_cmd_byte <= i_rx_byte;
            if ((r_byte_count + CSUM_OFFSET) == r_exp_len) r_csum_byte <= i_rx_byte;
            if (o_st.frame_done) begin
                r_tail_ok <= (i_rx_byte == r_tail_cfg);
                r_csum_ok <= (r_csum_byte == r_xor);
                r_plen    <= 6'(r_exp_len - OVERHEAD);
            end
        end
    end

    // Frame store: written on intake, read at the current payload position.
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_body) begin
            r_store[r_byte_count[STORE_AW-1:0]] <= i_rx_byte;
        end
        r_rdata <= r_store[rd_addr[STORE_AW-1:0]];
    end

    // Result index walks the payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_body && o_st.frame_done) begin
            r_idx <= '0;
        end else if (i_cmd.show) begin
            r_idx <= r_idx + 6'd1;
        end
    end

    // Output register; holds its transaction while stalled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.show) begin
            r_out_valid <= 1'b1;
        end else if (!i_res_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.show) begin
            if (!r_tail_ok) begin
                r_out_status <= STAT_BAD_TAIL;
            end else if (!r_csum_ok) begin
                r_out_status <= STAT_BAD_CSUM;
            end else begin
                r_out_status <= STAT_GOOD;
            end
            r_out_index <= good_payload ? r_idx : 6'd0;
            r_out_byte  <= good_payload ? r_rdata : 8'd0;
            r_out_last  <= o_st.show_last;
            o_command   <= r_cmd_byte;
            o_body_len  <= r_plen;
        end
    end

    assign o_res_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_byte_index   = r_out_index;
    assign o_payload_byte = r_out_byte;
    assign o_last         = r_out_last;

endmodule

// File: design/xor_checked_frame_deframer.sv
// Intake: one received byte per cycle while a frame is being parsed.
// Output: each result of a frame, starting after its closing byte, takes one frame
// store read (ST_READ) and one output load (ST_SHOW); intake is stalled through the
// result reads and loads, plus any result stall from downstream.
// Reset (synchronous, active low) returns to the head hunt and sets head to
// 0xAA and tail to 0xBB; the frame store is not cleared.
module xor_checked_frame_deframer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_rx_valid,
    output logic       o_rx_stall,
    input  logic [7:0] i_rx_byte,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_index,
    input  logic [7:0] i_cfg_data,
    output logic       o_res_valid,
    input  logic       i_res_stall,
    output logic [1:0] o_status,
    output logic [7:0] o_command,
    output logic [5:0] o_body_len,
    output logic [5:0] o_byte_index,
    output logic [7:0] o_payload_byte,
    output logic       o_last
);
    import xcfd_pkg::*;

    t_dp_cmd    dp_cmd;
    t_dp_status dp_st;

    // Configuration writes are always taken.
    assign o_cfg_ready = 1'b1;

    // Frame controller.
    xcfd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx_valid (i_rx_valid),
        .o_rx_stall (o_rx_stall),
        .i_st       (dp_st),
        .o_cmd      (dp_cmd)
    );

    // Frame datapath.
    xcfd_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_rx_byte      (i_rx_byte),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_res_stall    (i_res_stall),
        .o_res_valid    (o_res_valid),
        .o_status       (o_status),
        .o_command      (o_command),
        .o_body_len     (o_body_len),
        .o_byte_index   (o_byte_index),
        .o_payload_byte (o_payload_byte),
        .o_last         (o_last),
        .i_cmd          (dp_cmd),
        .o_st           (dp_st)
    );

endmodule
